@@ rtl/core/transform_matrix_accumulator_unit_macros.svh @@
// assertion macros for the transform matrix accumulator
`ifndef TRANSFORM_MATRIX_ACCUMULATOR_UNIT_MACROS_SVH
`define TRANSFORM_MATRIX_ACCUMULATOR_UNIT_MACROS_SVH
// same-cycle implication, checked outside reset
`define TMACC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication, checked outside reset
`define TMACC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/core/tmacc_pkg.sv @@
// shared types, constants and functions of the transform matrix accumulator
package tmacc_pkg;

  localparam int MATRIX_DIM   = 4;
  localparam int WORD_BITS    = 32;
  localparam int FRAC_BITS    = 16;
  localparam int ADDR_BITS    = 4;
  localparam int CORDIC_STEPS = 24;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [ADDR_BITS-1:0]        addr_t;
  typedef logic signed [33:0]          q30_t;

  localparam logic signed [63:0] WMAX64 = (64'sd1 <<< (WORD_BITS - 1)) - 64'sd1;
  localparam logic signed [63:0] WMIN64 = -WMAX64 - 64'sd1;
  localparam word_t              ONE    = word_t'(64'sd1 <<< FRAC_BITS);

  localparam logic signed [63:0] DEG90  = 64'sd90 <<< FRAC_BITS;
  localparam logic signed [63:0] DEG180 = 64'sd180 <<< FRAC_BITS;
  localparam logic signed [63:0] DEG360 = 64'sd360 <<< FRAC_BITS;

  // radians per degree in Q40, split into two partial products
  localparam logic signed [63:0] RAD_Q40 = 64'sd19190097741;
  localparam logic [16:0]        RAD_LO  = 17'(RAD_Q40);
  localparam logic [17:0]        RAD_HI  = 18'(RAD_Q40 >>> 17);
  localparam q30_t               CORDIC_GAIN = 34'sh026DD3B6A;

  typedef enum logic [1:0] {
    CMD_IDENT     = 2'd0,
    CMD_TRANSLATE = 2'd1,
    CMD_ROTATE    = 2'd2,
    CMD_READ      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TRANS,
    ST_ROT_START,
    ST_ROT_WAIT,
    ST_ROT_PROD,
    ST_ROT_MAC,
    ST_RD_FETCH,
    ST_RD_SHOW
  } top_state_t;

  typedef enum logic [2:0] {
    CD_IDLE,
    CD_MOD,
    CD_FOLD,
    CD_MUL_LO,
    CD_MUL_HI,
    CD_ITER,
    CD_FIN,
    CD_DONE
  } cordic_state_t;

  typedef struct packed {
    logic  clr;
    logic  we;
    addr_t waddr;
    word_t wdata;
    addr_t raddr;
  } mem_req_t;

  function automatic word_t sat_word(input logic signed [63:0] v);
    word_t r;
    if (v > WMAX64) begin
      r = word_t'(WMAX64);
    end else if (v < WMIN64) begin
      r = word_t'(WMIN64);
    end else begin
      r = word_t'(v);
    end
    return r;
  endfunction

  function automatic word_t ident_word(input addr_t a);
    return (a[1:0] == a[3:2]) ? ONE : '0;
  endfunction

  function automatic q30_t atan_q30(input logic [4:0] i);
    q30_t r;
    case (i)
      5'd0:    r = 34'sh03243F6A8;
      5'd1:    r = 34'sh01DAC6705;
      5'd2:    r = 34'sh00FADBAFC;
      5'd3:    r = 34'sh007F56EA6;
      5'd4:    r = 34'sh003FEAB76;
      5'd5:    r = 34'sh001FFD55B;
      5'd6:    r = 34'sh000FFFAAA;
      5'd7:    r = 34'sh0007FFF55;
      5'd8:    r = 34'sh0003FFFEA;
      5'd9:    r = 34'sh0001FFFFD;
      5'd10:   r = 34'sh0000FFFFF;
      5'd11:   r = 34'sh00007FFFF;
      5'd12:   r = 34'sh00003FFFF;
      5'd13:   r = 34'sh00001FFFF;
      5'd14:   r = 34'sh00000FFFF;
      5'd15:   r = 34'sh000007FFF;
      5'd16:   r = 34'sh000003FFF;
      5'd17:   r = 34'sh000001FFF;
      5'd18:   r = 34'sh000000FFF;
      5'd19:   r = 34'sh0000007FF;
      5'd20:   r = 34'sh0000003FF;
      5'd21:   r = 34'sh0000001FF;
      5'd22:   r = 34'sh0000000FF;
      5'd23:   r = 34'sh00000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/core/tmacc_mem.sv @@
// matrix store: 16 words, registered read, per-entry valid bits for identity reset
module tmacc_mem (
  input  logic                clk,
  input  logic                rst,
  input  tmacc_pkg::mem_req_t req,
  output tmacc_pkg::word_t    rdata
);
  import tmacc_pkg::*;

  word_t mem [MATRIX_DIM*MATRIX_DIM];
  logic [MATRIX_DIM*MATRIX_DIM-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      valid <= '0;
    end else if (req.we) begin
      valid[req.waddr] <= 1'b1;
    end
  end

  // unwritten entries read as identity
  always_ff @(posedge clk) begin
    rdata <= valid[req.raddr] ? mem[req.raddr] : ident_word(req.raddr);
  end

endmodule

@@ rtl/core/tmacc_cordic.sv @@
// sine and cosine of an angle in degrees: range reduction and iterative cordic
module tmacc_cordic (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  tmacc_pkg::word_t angle,
  output logic             done,
  output tmacc_pkg::word_t cos_val,
  output tmacc_pkg::word_t sin_val
);
  import tmacc_pkg::*;

  localparam logic signed [27:0] D90  = 28'(DEG90);
  localparam logic signed [27:0] D180 = 28'(DEG180);
  localparam logic signed [27:0] D360 = 28'(DEG360);
  // ceil(2^24 / 360), exact quotient for any 16-bit whole-degree count
  localparam logic [15:0]        RECIP_360 = 16'd46604;

  cordic_state_t state, state_next;
  logic [31:0]   mag;
  logic          ang_neg;
  logic [4:0]    cnt;
  logic signed [25:0] a_fold;
  logic          fold_neg;
  logic signed [43:0] p_lo;
  q30_t          x, y, z;
  logic [6:0]    quo;

  logic signed [27:0] a_calc;
  logic          fneg_calc;
  logic [31:0]   q_prod;
  logic [15:0]   quo_360;
  logic [15:0]   rem_int;
  logic signed [43:0] pl;
  logic signed [44:0] ph;
  logic signed [59:0] p_full;
  q30_t          dx, dy, at;
  logic signed [63:0] xr, yr;
  word_t         cq, sq, cos_n, sin_n;

  // fold the remainder into [-90, 90]
  always_comb begin
    a_calc    = $signed({3'b000, mag[24:0]});
    fneg_calc = 1'b0;
    if (ang_neg) begin
      a_calc = -a_calc;
    end
    if (a_calc < 0) begin
      a_calc = a_calc + D360;
    end
    if (a_calc >= D180) begin
      a_calc = a_calc - D360;
    end
    if (a_calc > D90) begin
      a_calc    = a_calc - D180;
      fneg_calc = 1'b1;
    end else if (a_calc < -D90) begin
      a_calc    = a_calc + D180;
      fneg_calc = 1'b1;
    end
  end

  always_comb begin
    q_prod  = mag[31:16] * RECIP_360;
    quo_360 = 16'(quo) * 16'd360;
    rem_int = mag[31:16] - quo_360;
    pl      = a_fold * $signed({1'b0, RAD_LO});
    ph      = a_fold * $signed({1'b0, RAD_HI});
    p_full  = 60'(p_lo) + (60'(ph) <<< 17);
    dx      = y >>> cnt;
    dy      = x >>> cnt;
    at      = atan_q30(cnt);
    xr      = (64'(x) + 64'sd8192) >>> (30 - FRAC_BITS);
    yr      = (64'(y) + 64'sd8192) >>> (30 - FRAC_BITS);
    cq      = sat_word(xr);
    sq      = sat_word(yr);
    cos_n   = fold_neg ? sat_word(-64'(cq)) : cq;
    sin_n   = fold_neg ? sat_word(-64'(sq)) : sq;
  end

  always_comb begin
    state_next = state;
    case (state)
      CD_IDLE:   if (start) state_next = CD_MOD;
      CD_MOD:    if (cnt == 5'd0) state_next = CD_FOLD;
      CD_FOLD:   state_next = CD_MUL_LO;
      CD_MUL_LO: state_next = CD_MUL_HI;
      CD_MUL_HI: state_next = CD_ITER;
      CD_ITER:   if (cnt == 5'(CORDIC_STEPS - 1)) state_next = CD_FIN;
      CD_FIN:    state_next = CD_DONE;
      CD_DONE:   state_next = CD_IDLE;
      default:   state_next = CD_IDLE;
    endcase
  end

  always_comb begin
    done = (state == CD_DONE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CD_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CD_IDLE: begin
        if (start) begin
          mag     <= angle[31] ? (~angle + 32'd1) : angle;
          ang_neg <= angle[31];
          cnt     <= 5'd1;
        end
      end
      CD_MOD: begin
        // modulo 360 on whole degrees: reciprocal quotient, then remainder
        if (cnt == 5'd1) begin
          quo <= q_prod[30:24];
        end else begin
          mag <= {rem_int, mag[15:0]};
        end
        cnt <= cnt - 5'd1;
      end
      CD_FOLD: begin
        a_fold   <= a_calc[25:0];
        fold_neg <= fneg_calc;
      end
      CD_MUL_LO: begin
        p_lo <= pl;
      end
      CD_MUL_HI: begin
        z   <= 34'(p_full >>> 26);
        x   <= CORDIC_GAIN;
        y   <= '0;
        cnt <= '0;
      end
      CD_ITER: begin
        if (!z[33]) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        cnt <= cnt + 5'd1;
      end
      CD_FIN: begin
        cos_val <= cos_n;
        sin_val <= sin_n;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ rtl/core/transform_matrix_accumulator_unit.sv @@
// transform matrix accumulator top level: command sequencer, shared multiplier, row output
// commands: load identity, translate, read row by row with each row held while stalled;
// rotate runs a cordic pass, 15 products and 4 column passes over rows 0-2
// throughput: one command at a time; the one-read one-write matrix store and one 32x32
// multiplier serialise the work; rows leave one per transaction once fetched
// reset: sync, active high; the matrix reads as identity through cleared valid bits
module transform_matrix_accumulator_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_stall,
  input  logic [1:0]       command,
  input  tmacc_pkg::word_t vec_x,
  input  tmacc_pkg::word_t vec_y,
  input  tmacc_pkg::word_t vec_z,
  input  tmacc_pkg::word_t angle_deg,
  output logic             row_valid,
  input  logic             row_stall,
  output logic [1:0]       row_index,
  output tmacc_pkg::word_t elem0,
  output tmacc_pkg::word_t elem1,
  output tmacc_pkg::word_t elem2,
  output tmacc_pkg::word_t elem3,
  output logic             last_row
);
  import tmacc_pkg::*;
  `include "transform_matrix_accumulator_unit_macros.svh"

  top_state_t state, state_next;
  logic [4:0] step;
  logic [3:0] mstep;
  logic [1:0] col;
  logic [1:0] rrow;

  // latched command operands
  word_t vx, vy, vz, ang;

  mem_req_t req;
  word_t    rdata;

  // shared multiplier: operands registered, product registered
  word_t mul_a, mul_b, a_op, b_op;
  logic signed [63:0] prod;
  logic signed [47:0] prod_sh;
  word_t prod_q;

  logic  cd_start, cd_done;
  word_t cd_cos, cd_sin;
  word_t oc;

  // intermediate products of the rotation set-up
  word_t pv [15];
  logic [3:0] pv_idx;
  word_t colv [3];
  logic signed [49:0] acc;

  word_t r00, r01, r02, r10, r11, r12, r20, r21, r22;

  tmacc_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

  tmacc_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cd_start),
    .angle   (ang),
    .done    (cd_done),
    .cos_val (cd_cos),
    .sin_val (cd_sin)
  );

  assign prod_sh = $signed(prod[63:FRAC_BITS]);
  assign prod_q  = sat_word(64'(prod_sh));
  assign pv_idx  = 4'(step - 5'd2);

  // rotation matrix terms in its transposed axis-angle form
  always_comb begin
    r00 = sat_word(64'(pv[6])  + 64'(cd_cos));
    r01 = sat_word(64'(pv[9])  + 64'(pv[12]));
    r02 = sat_word(64'(pv[10]) - 64'(pv[13]));
    r10 = sat_word(64'(pv[9])  - 64'(pv[12]));
    r11 = sat_word(64'(pv[7])  + 64'(cd_cos));
    r12 = sat_word(64'(pv[11]) + 64'(pv[14]));
    r20 = sat_word(64'(pv[10]) + 64'(pv[13]));
    r21 = sat_word(64'(pv[11]) - 64'(pv[14]));
    r22 = sat_word(64'(pv[8])  + 64'(cd_cos));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          case (cmd_t'(command))
            CMD_IDENT:     state_next = ST_IDLE;
            CMD_TRANSLATE: state_next = ST_TRANS;
            CMD_ROTATE:    state_next = ST_ROT_START;
            CMD_READ:      state_next = ST_RD_FETCH;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_TRANS:     if (step == 5'd4) state_next = ST_IDLE;
      ST_ROT_START: state_next = ST_ROT_WAIT;
      ST_ROT_WAIT:  if (cd_done) state_next = ST_ROT_PROD;
      ST_ROT_PROD:  if (step == 5'd16) state_next = ST_ROT_MAC;
      ST_ROT_MAC:   if (mstep == 4'd14 && col == 2'd3) state_next = ST_IDLE;
      ST_RD_FETCH:  if (step == 5'd4) state_next = ST_RD_SHOW;
      ST_RD_SHOW: begin
        if (!row_stall) begin
          state_next = (rrow == 2'd3) ? ST_IDLE : ST_RD_FETCH;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs, store requests and multiplier operands
  always_comb begin
    cmd_stall = (state != ST_IDLE);
    row_valid = (state == ST_RD_SHOW);
    cd_start  = (state == ST_ROT_START);
    req       = '0;
    mul_a     = '0;
    mul_b     = '0;
    case (state)
      ST_IDLE: begin
        req.clr = cmd_valid && (cmd_t'(command) == CMD_IDENT);
      end
      ST_TRANS: begin
        // column 3 of rows 0-2 gets the offsets, then element [3][3] becomes one
        case (step)
          5'd0: req.raddr = 4'd3;
          5'd1: begin
            req.raddr = 4'd7;
            req.we    = 1'b1;
            req.waddr = 4'd3;
            req.wdata = sat_word(64'(rdata) + 64'(vx));
          end
          5'd2: begin
            req.raddr = 4'd11;
            req.we    = 1'b1;
            req.waddr = 4'd7;
            req.wdata = sat_word(64'(rdata) + 64'(vy));
          end
          5'd3: begin
            req.we    = 1'b1;
            req.waddr = 4'd11;
            req.wdata = sat_word(64'(rdata) + 64'(vz));
          end
          5'd4: begin
            req.we    = 1'b1;
            req.waddr = 4'd15;
            req.wdata = ONE;
          end
          default: begin
          end
        endcase
      end
      ST_ROT_PROD: begin
        // axis products, then their products with 1 - cos, then axis times sin
        case (step)
          5'd0:  begin mul_a = vx;    mul_b = vx;     end
          5'd1:  begin mul_a = vy;    mul_b = vy;     end
          5'd2:  begin mul_a = vz;    mul_b = vz;     end
          5'd3:  begin mul_a = vx;    mul_b = vy;     end
          5'd4:  begin mul_a = vx;    mul_b = vz;     end
          5'd5:  begin mul_a = vy;    mul_b = vz;     end
          5'd6:  begin mul_a = pv[0]; mul_b = oc;     end
          5'd7:  begin mul_a = pv[1]; mul_b = oc;     end
          5'd8:  begin mul_a = pv[2]; mul_b = oc;     end
          5'd9:  begin mul_a = pv[3]; mul_b = oc;     end
          5'd10: begin mul_a = pv[4]; mul_b = oc;     end
          5'd11: begin mul_a = pv[5]; mul_b = oc;     end
          5'd12: begin mul_a = vz;    mul_b = cd_sin; end
          5'd13: begin mul_a = vy;    mul_b = cd_sin; end
          5'd14: begin mul_a = vx;    mul_b = cd_sin; end
          default: begin
          end
        endcase
      end
      ST_ROT_MAC: begin
        // one column at a time: fetch rows 0-2, nine products, write back rows 0-2
        if (mstep inside {[4'd0:4'd2]}) begin
          req.raddr = {mstep[1:0], col};
        end
        case (mstep)
          4'd4:  begin mul_a = r00; mul_b = colv[0]; end
          4'd5:  begin mul_a = r01; mul_b = colv[1]; end
          4'd6:  begin mul_a = r02; mul_b = colv[2]; end
          4'd7:  begin mul_a = r10; mul_b = colv[0]; end
          4'd8:  begin mul_a = r11; mul_b = colv[1]; end
          4'd9:  begin mul_a = r12; mul_b = colv[2]; end
          4'd10: begin mul_a = r20; mul_b = colv[0]; end
          4'd11: begin mul_a = r21; mul_b = colv[1]; end
          4'd12: begin mul_a = r22; mul_b = colv[2]; end
          default: begin
          end
        endcase
        req.wdata = sat_word(64'(acc + prod_sh));
        case (mstep)
          4'd8: begin
            req.we    = 1'b1;
            req.waddr = {2'd0, col};
          end
          4'd11: begin
            req.we    = 1'b1;
            req.waddr = {2'd1, col};
          end
          4'd14: begin
            req.we    = 1'b1;
            req.waddr = {2'd2, col};
          end
          default: begin
          end
        endcase
      end
      ST_RD_FETCH: begin
        req.raddr = {rrow, step[1:0]};
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
      mstep <= '0;
      col   <= '0;
      rrow  <= '0;
    end else begin
      state <= state_next;
      if (state != state_next) begin
        step <= '0;
      end else begin
        step <= step + 5'd1;
      end
      if (state == ST_ROT_MAC) begin
        if (mstep == 4'd14) begin
          mstep <= '0;
          col   <= col + 2'd1;
        end else begin
          mstep <= mstep + 4'd1;
        end
      end else begin
        mstep <= '0;
        col   <= '0;
      end
      if (state == ST_IDLE) begin
        rrow <= '0;
      end else if (state == ST_RD_SHOW && !row_stall) begin
        rrow <= rrow + 2'd1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      vx  <= vec_x;
      vy  <= vec_y;
      vz  <= vec_z;
      ang <= angle_deg;
    end
    a_op <= mul_a;
    b_op <= mul_b;
    prod <= a_op * b_op;
    if (state == ST_ROT_WAIT && cd_done) begin
      oc <= sat_word(64'(ONE) - 64'(cd_cos));
    end
    if (state == ST_ROT_PROD && step >= 5'd2) begin
      pv[pv_idx] <= prod_q;
    end
    if (state == ST_ROT_MAC) begin
      case (mstep)
        4'd1: colv[0] <= rdata;
        4'd2: colv[1] <= rdata;
        4'd3: colv[2] <= rdata;
        4'd6, 4'd9, 4'd12: acc <= 50'(prod_sh);
        4'd7, 4'd10, 4'd13: acc <= acc + 50'(prod_sh);
        default: begin
        end
      endcase
    end
    if (state == ST_RD_FETCH) begin
      case (step)
        5'd1: elem0 <= rdata;
        5'd2: elem1 <= rdata;
        5'd3: elem2 <= rdata;
        5'd4: elem3 <= rdata;
        default: begin
        end
      endcase
    end
  end

  assign row_index = rrow;
  assign last_row  = (rrow == 2'd3);

  // no new command while a row transaction is pending
  `TMACC_ASSERT_IMP(a_row_blocks_cmd, row_valid, cmd_stall, "command taken during row output")
  // the sine and cosine unit only finishes while the sequencer waits for it
  `TMACC_ASSERT_IMP(a_cordic_done_wait, cd_done, state == ST_ROT_WAIT, "unexpected cordic done")
  // after the final row is taken the read is over
  `TMACC_ASSERT_NXT(a_last_row_ends, row_valid && !row_stall && last_row, !row_valid,
                    "row output continues after last row")
  // store writes never collide with a clear
  `TMACC_ASSERT_IMP(a_no_write_on_clr, req.clr, !req.we, "write during clear")

endmodule

@@ sim/transform_matrix_accumulator_unit_tb.sv @@
// testbench for the transform matrix accumulator: directed and random commands checked against a predictor
`timescale 1ns / 100ps

module transform_matrix_accumulator_unit_tb;
  import tmacc_pkg::*;

  // one command transaction as driven onto the ports
  typedef struct packed {
    cmd_t  op;
    word_t vx;
    word_t vy;
    word_t vz;
    word_t ang;
  } cmd_item_t;

  // one row transaction as expected on the output
  typedef struct packed {
    logic [1:0] idx;
    word_t      e0;
    word_t      e1;
    word_t      e2;
    word_t      e3;
    logic       last;
  } row_item_t;

  logic       clk;
  logic       rst;
  logic       cmd_valid;
  logic       cmd_stall;
  logic [1:0] command;
  word_t      vec_x;
  word_t      vec_y;
  word_t      vec_z;
  word_t      angle_deg;
  logic       row_valid;
  logic       row_stall;
  logic [1:0] row_index;
  word_t      elem0;
  word_t      elem1;
  word_t      elem2;
  word_t      elem3;
  logic       last_row;

  transform_matrix_accumulator_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .command   (command),
    .vec_x     (vec_x),
    .vec_y     (vec_y),
    .vec_z     (vec_z),
    .angle_deg (angle_deg),
    .row_valid (row_valid),
    .row_stall (row_stall),
    .row_index (row_index),
    .elem0     (elem0),
    .elem1     (elem1),
    .elem2     (elem2),
    .elem3     (elem3),
    .last_row  (last_row)
  );

  // 12 ns period
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // predictor copy of the matrix, row-major, held as 64-bit signed for headroom
  logic signed [63:0] xform [16];

  cmd_item_t pending_cmds [$];
  row_item_t expected_rows [$];
  int        error_count;
  int        rows_checked;
  int        cmds_sent;
  int        rotates_sent;

  localparam logic signed [63:0] ONE64 = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] GAIN_Q30 = 64'sh26DD3B6A;
  localparam logic signed [63:0] RAD_PER_DEG = 64'sd19190097741;

  // floor shift, saturation and Q16.16 multiply as the hardware defines them
  function automatic logic signed [63:0] clip(input logic signed [63:0] v);
    if (v > WMAX64) return WMAX64;
    if (v < WMIN64) return WMIN64;
    return v;
  endfunction

  function automatic logic signed [63:0] fmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    return clip((a * b) >>> FRAC_BITS);
  endfunction

  function automatic logic signed [63:0] q30_round(input logic signed [63:0] v);
    return clip((v + (64'sd1 <<< (30 - FRAC_BITS - 1))) >>> (30 - FRAC_BITS));
  endfunction

  function automatic logic signed [63:0] arctan_step(input int i);
    logic signed [63:0] t [24];
    t = '{64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
          64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
          64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
          64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
          64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F};
    return t[i];
  endfunction

  // cordic sine and cosine of an angle in Q16.16 degrees
  task automatic cordic_sin_cos(input logic signed [63:0] deg,
                                output logic signed [63:0] c,
                                output logic signed [63:0] s);
    logic signed [63:0] a, x, y, z, dx, dy;
    logic signed [63:0] d90, d180, d360;
    bit flip;
    d90 = DEG90;
    d180 = DEG180;
    d360 = DEG360;
    flip = 1'b0;
    // truncating remainder, then into [-180, 180)
    a = deg % d360;
    if (a < 0) a = a + d360;
    if (a >= d180) a = a - d360;
    // fold into [-90, 90], which negates both outputs
    if (a > d90) begin
      a = a - d180;
      flip = 1'b1;
    end else if (a < -d90) begin
      a = a + d180;
      flip = 1'b1;
    end
    z = (a * RAD_PER_DEG) >>> (10 + FRAC_BITS);
    x = GAIN_Q30;
    y = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - arctan_step(i);
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + arctan_step(i);
      end
    end
    c = q30_round(x);
    s = q30_round(y);
    if (flip) begin
      c = clip(-c);
      s = clip(-s);
    end
  endtask

  task automatic load_identity();
    for (int i = 0; i < 16; i++) xform[i] = (i % 5 == 0) ? ONE64 : 64'sd0;
  endtask

  // axis-angle rotation in the transposed form, pre-multiplied onto the matrix
  task automatic apply_rotation(input logic signed [63:0] x, input logic signed [63:0] y,
                                input logic signed [63:0] z, input logic signed [63:0] deg);
    logic signed [63:0] r [16];
    logic signed [63:0] t [16];
    logic signed [63:0] c, s, oc, xx, yy, zz, xy, xz, yz, acc;
    cordic_sin_cos(deg, c, s);
    oc = clip(ONE64 - c);
    xx = fmul(x, x);
    yy = fmul(y, y);
    zz = fmul(z, z);
    xy = fmul(x, y);
    xz = fmul(x, z);
    yz = fmul(y, z);
    for (int i = 0; i < 16; i++) r[i] = 0;
    r[0]  = clip(fmul(xx, oc) + c);
    r[1]  = clip(fmul(xy, oc) + fmul(z, s));
    r[2]  = clip(fmul(xz, oc) - fmul(y, s));
    r[4]  = clip(fmul(xy, oc) - fmul(z, s));
    r[5]  = clip(fmul(yy, oc) + c);
    r[6]  = clip(fmul(yz, oc) + fmul(x, s));
    r[8]  = clip(fmul(xz, oc) + fmul(y, s));
    r[9]  = clip(fmul(yz, oc) - fmul(x, s));
    r[10] = clip(fmul(zz, oc) + c);
    r[15] = ONE64;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        acc = 0;
        for (int k = 0; k < 4; k++) acc = acc + ((r[i*4+k] * xform[k*4+j]) >>> FRAC_BITS);
        t[i*4+j] = clip(acc);
      end
    end
    for (int i = 0; i < 16; i++) xform[i] = t[i];
  endtask

  // advances the predictor by one accepted command, queuing any rows it yields
  task automatic predict_command(input cmd_item_t it);
    row_item_t row;
    case (it.op)
      CMD_IDENT: load_identity();
      CMD_TRANSLATE: begin
        xform[3]  = clip(xform[3] + it.vx);
        xform[7]  = clip(xform[7] + it.vy);
        xform[11] = clip(xform[11] + it.vz);
        xform[15] = ONE64;
      end
      CMD_ROTATE: apply_rotation(it.vx, it.vy, it.vz, it.ang);
      default: begin
        for (int i = 0; i < 4; i++) begin
          row.idx  = 2'(i);
          row.e0   = word_t'(xform[i*4]);
          row.e1   = word_t'(xform[i*4+1]);
          row.e2   = word_t'(xform[i*4+2]);
          row.e3   = word_t'(xform[i*4+3]);
          row.last = (i == 3);
          expected_rows.push_back(row);
        end
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  // command acceptance as seen at the rising edge
  bit cmd_taken;

  always @(posedge clk) begin
    cmd_taken <= !rst && cmd_valid && !cmd_stall;
  end

  // driver: gap drawn per transaction, inputs moved on the falling edge
  int gap_left;
  bit gap_drawn;

  always @(negedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      command   <= CMD_IDENT;
      vec_x     <= '0;
      vec_y     <= '0;
      vec_z     <= '0;
      angle_deg <= '0;
      gap_drawn <= 1'b0;
    end else if (cmd_taken) begin
      // previous transaction was taken at the last rising edge
      if (pending_cmds[0].op == CMD_ROTATE) rotates_sent++;
      predict_command(pending_cmds.pop_front());
      cmds_sent++;
      gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
      if (gap_left == 0 && pending_cmds.size() > 0) begin
        present_next();
      end else begin
        cmd_valid <= 1'b0;
        gap_drawn <= 1'b1;
      end
    end else if (!cmd_valid && pending_cmds.size() > 0) begin
      if (!gap_drawn) begin
        gap_left = $urandom_range(0, 18);
        gap_drawn <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else begin
        present_next();
      end
    end
  end

  task automatic present_next();
    cmd_item_t it;
    it = pending_cmds[0];
    cmd_valid <= 1'b1;
    command   <= it.op;
    vec_x     <= it.vx;
    vec_y     <= it.vy;
    vec_z     <= it.vz;
    angle_deg <= it.ang;
    gap_drawn <= 1'b0;
  endtask

  // receiver stall, redrawn for each row
  int stall_left;

  always @(negedge clk) begin
    if (rst) begin
      row_stall  <= 1'b0;
      stall_left = 0;
    end else if (row_valid && !row_stall) begin
      stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 18);
      row_stall <= (stall_left > 0);
    end else if (stall_left > 0) begin
      stall_left--;
      row_stall <= (stall_left > 0);
    end else begin
      row_stall <= 1'b0;
    end
  end

  // monitor: rows taken at the rising edge compared with the oldest expectation
  always @(posedge clk) begin
    row_item_t want;
    if (!rst && row_valid && !row_stall) begin
      if (expected_rows.size() == 0) begin
        report_mismatch("unexpected row", 32'(row_index), 32'hx);
      end else begin
        want = expected_rows.pop_front();
        rows_checked++;
        if (row_index !== want.idx) report_mismatch("row_index", 32'(row_index), 32'(want.idx));
        if (elem0 !== want.e0) report_mismatch("elem0", elem0, want.e0);
        if (elem1 !== want.e1) report_mismatch("elem1", elem1, want.e1);
        if (elem2 !== want.e2) report_mismatch("elem2", elem2, want.e2);
        if (elem3 !== want.e3) report_mismatch("elem3", elem3, want.e3);
        if (last_row !== want.last) report_mismatch("last_row", 32'(last_row), 32'(want.last));
      end
    end
  end

  function automatic cmd_item_t make_cmd(input cmd_t op, input word_t x, input word_t y,
                                         input word_t z, input word_t a);
    cmd_item_t it;
    it.op = op;
    it.vx = x;
    it.vy = y;
    it.vz = z;
    it.ang = a;
    return it;
  endfunction

  // mostly modest axes and angles so rotations stay meaningful, with full-range noise
  function automatic word_t rand_word(input int mode);
    case (mode)
      0: return word_t'($urandom);
      1: return word_t'($signed($urandom_range(0, 2 * 65536)) - 65536);
      default: return word_t'($signed($urandom_range(0, 800 * 65536)) - 400 * 65536);
    endcase
  endfunction

  function automatic cmd_item_t rand_cmd();
    int sel;
    int wide;
    sel = $urandom_range(0, 9);
    wide = ($urandom_range(0, 5) == 0) ? 0 : 1;
    if (sel < 3) return make_cmd(CMD_READ, rand_word(0), rand_word(0), rand_word(0),
                                 rand_word(0));
    if (sel < 6) return make_cmd(CMD_ROTATE, rand_word(wide ? 1 : 0), rand_word(wide ? 1 : 0),
                                 rand_word(wide ? 1 : 0), rand_word(wide ? 2 : 0));
    if (sel < 9) return make_cmd(CMD_TRANSLATE, rand_word(wide ? 2 : 0),
                                 rand_word(wide ? 2 : 0), rand_word(wide ? 2 : 0),
                                 rand_word(0));
    return make_cmd(CMD_IDENT, rand_word(0), rand_word(0), rand_word(0), rand_word(0));
  endfunction

  initial begin
    word_t wmax, wmin;
    wmax = word_t'(WMAX64);
    wmin = word_t'(WMIN64);
    rst = 1'b1;
    error_count = 0;
    rows_checked = 0;
    cmds_sent = 0;
    rotates_sent = 0;
    load_identity();

    // directed: identity read after reset, saturating translates, special angles,
    // degenerate axis, huge axis and angle extremes
    pending_cmds.push_back(make_cmd(CMD_READ, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_TRANSLATE, wmax, wmin, 32'sh0001_8000, '0));
    pending_cmds.push_back(make_cmd(CMD_TRANSLATE, wmax, wmin, -32'sd1, '0));
    pending_cmds.push_back(make_cmd(CMD_READ, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, '0, '0, ONE, 32'sd90 <<< 16));
    pending_cmds.push_back(make_cmd(CMD_READ, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_IDENT, wmax, wmax, wmax, wmax));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, ONE, '0, '0, 32'sd180 <<< 16));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, '0, ONE, '0, -(32'sd180 <<< 16)));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, '0, '0, '0, 32'sd45 <<< 16));
    pending_cmds.push_back(make_cmd(CMD_READ, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_IDENT, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, wmax, wmin, wmax, wmax));
    pending_cmds.push_back(make_cmd(CMD_READ, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, 32'sh0000_B505, 32'sh0000_B505, '0, wmin));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, ONE, ONE, ONE, 32'sd360 <<< 16));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, ONE, '0, ONE, -(32'sd90 <<< 16)));
    pending_cmds.push_back(make_cmd(CMD_READ, -32'sd1, -32'sd1, -32'sd1, -32'sd1));
    pending_cmds.push_back(make_cmd(CMD_IDENT, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_ROTATE, wmin, wmin, wmin, 32'sd270 <<< 16));
    pending_cmds.push_back(make_cmd(CMD_READ, '0, '0, '0, '0));
    pending_cmds.push_back(make_cmd(CMD_IDENT, '0, '0, '0, '0));

    // random part
    for (int n = 0; n < 360; n++) pending_cmds.push_back(rand_cmd());
    pending_cmds.push_back(make_cmd(CMD_READ, '0, '0, '0, '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    wait (pending_cmds.size() == 0 && !cmd_valid);
    wait (expected_rows.size() == 0);
    repeat (200) @(posedge clk);

    $display("covered %0d commands (%0d rotations), %0d rows compared, with random gaps and stalls",
             cmds_sent, rotates_sent, rows_checked);
    if (error_count == 0 && expected_rows.size() == 0) begin
      $display("transform_matrix_accumulator_unit regression: pass");
    end else begin
      $display("transform_matrix_accumulator_unit regression: fail");
    end
    $finish;
  end

  // watchdog: well beyond the slowest correct run
  initial begin
    #(12 * 600000);
    $display("timeout with %0d rows outstanding", expected_rows.size());
    $display("transform_matrix_accumulator_unit regression: fail");
    $finish;
  end

endmodule

@@ transform_matrix_accumulator_unit.f @@
+incdir+rtl/core
rtl/core/tmacc_pkg.sv
rtl/core/tmacc_mem.sv
rtl/core/tmacc_cordic.sv
rtl/core/transform_matrix_accumulator_unit.sv
sim/transform_matrix_accumulator_unit_tb.sv
